/* design/xeef_pkg.sv */
// Package for the XML element end finder.
// Holds the character codes, quote mode codes, nesting count limits and length width used by the scanner.
// No dependencies.
package xeef_pkg;

    // Characters that steer the scan
    localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
    localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
    localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
    localparam logic [7:0] CH_DQUOTE = 8'h22;  // double quote
    localparam logic [7:0] CH_SQUOTE = 8'h27;  // single quote

    // Quote mode codes
    typedef logic [1:0] t_quote;
    localparam t_quote QUOTE_NONE   = 2'd0;
    localparam t_quote QUOTE_DOUBLE = 2'd1;
    localparam t_quote QUOTE_SINGLE = 2'd2;

    // Nesting count and its limits
    localparam int NEST_W = 16;
    typedef logic signed [NEST_W-1:0] t_nest;
    localparam logic signed [NEST_W+1:0] NEST_MAX = 18'sd32767;
    localparam logic signed [NEST_W+1:0] NEST_MIN = -18'sd32768;

    // Width of the reported length
    localparam int LEN_OUT_W = 16;

endpackage

/* design/xml_element_end_finder.sv */
// XML element end finder: top level, scans one text byte per request.
// Depends on xeef_pkg.
//
// Usage:
//   Slave stream: s_axis_tdata carries one byte of XML text, s_axis_tlast
//   marks the final byte available in the buffer. A request is taken when
//   s_axis_tvalid and s_axis_tready are both high.
//   Master stream: one result per finished scan. m_axis_tuser is the found
//   flag, m_axis_tdata the consumed length (bytes up to and including the
//   closing '>', zero when not found).
//   Configuration: i_cfg_wr_en writes i_cfg_wr_data as the signed target
//   nesting level; write it only while the block is idle.
// Timing:
//   One byte per cycle sustained while m_axis_tready does not hold a result.
//   The byte that ends the scan passes through the input register, then the
//   scan logic, into the output register, from which the result is presented.
// Reset (i_rst_n low, synchronous): target level 0, scan state cleared,
//   both pipeline registers empty.
// Stall: while m_axis_tready is low the result holds; one more byte waits
//   in the input register, after which s_axis_tready drops.
module xml_element_end_finder #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,     // target_level, signed
    // text stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,      // [7:0] text_byte
    input  logic        s_axis_tlast,      // is_last
    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,      // [15:0] consumed_length
    output logic        m_axis_tuser       // [0] found
);

    localparam int EXT_W = (LENGTH_BITS > xeef_pkg::LEN_OUT_W) ?
                           LENGTH_BITS : xeef_pkg::LEN_OUT_W;
    localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

    // Configuration register
    logic signed [7:0] r_target;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // Scan state
    xeef_pkg::t_nest          r_nest, n_nest;
    xeef_pkg::t_quote         r_quote, n_quote;
    logic                     r_slash_seen, n_slash_seen;
    logic                     r_prev_slash, n_prev_slash;
    logic [LENGTH_BITS-1:0]   r_count, n_count;

    // Output register
    logic        r_out_valid;
    logic        r_out_found;
    logic [15:0] r_out_len;

    logic                              w_proc_ok;
    logic                              w_close;
    logic                              w_hit;
    logic                              w_emit;
    logic signed [xeef_pkg::NEST_W+1:0] w_delta;
    logic signed [xeef_pkg::NEST_W+1:0] w_sum;
    logic                              w_nest_upd;
    xeef_pkg::t_nest                   w_nest_sat;
    logic [EXT_W-1:0]                  w_cnt_ext;
    logic [15:0]                       w_len;

    // Stage hand-off: process when the output register is free or draining
    assign w_proc_ok     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_proc_ok;

    // Saturating add on the nesting count
    assign w_sum = {{2{r_nest[xeef_pkg::NEST_W-1]}}, r_nest} + w_delta;
    always_comb begin
        if (w_sum > xeef_pkg::NEST_MAX) begin
            w_nest_sat = xeef_pkg::t_nest'(xeef_pkg::NEST_MAX);
        end else if (w_sum < xeef_pkg::NEST_MIN) begin
            w_nest_sat = xeef_pkg::t_nest'(xeef_pkg::NEST_MIN);
        end else begin
            w_nest_sat = w_sum[xeef_pkg::NEST_W-1:0];
        end
    end

    // Reported length, clamped to the output width
    always_comb begin
        w_cnt_ext = EXT_W'(n_count);
        if (w_cnt_ext > EXT_W'(17'h0FFFF)) begin
            w_len = 16'hFFFF;
        end else begin
            w_len = w_cnt_ext[15:0];
        end
    end

    // Scan one byte
    always_comb begin
        n_quote      = r_quote;
        n_slash_seen = r_slash_seen;
        n_prev_slash = 1'b0;
        n_count      = (r_count != CNT_MAX) ? r_count + 1'b1 : r_count;
        w_delta      = '0;
        w_nest_upd   = 1'b0;
        w_close      = 1'b0;
        case (r_quote)
            xeef_pkg::QUOTE_DOUBLE: begin
                if (r_in_byte == xeef_pkg::CH_DQUOTE) n_quote = xeef_pkg::QUOTE_NONE;
            end
            xeef_pkg::QUOTE_SINGLE: begin
                if (r_in_byte == xeef_pkg::CH_SQUOTE) n_quote = xeef_pkg::QUOTE_NONE;
            end
            default: begin
                case (r_in_byte)
                    xeef_pkg::CH_LT: begin
                        w_delta    = 18'sd1;
                        w_nest_upd = 1'b1;
                    end
                    xeef_pkg::CH_SLASH: begin
                        n_slash_seen = 1'b1;
                        n_prev_slash = 1'b1;
                    end
                    xeef_pkg::CH_GT: begin
                        if (r_slash_seen) begin
                            w_delta      = r_prev_slash ? -18'sd1 : -18'sd2;
                            w_nest_upd   = 1'b1;
                            n_slash_seen = 1'b0;
                            w_close      = 1'b1;
                        end
                    end
                    xeef_pkg::CH_DQUOTE: n_quote = xeef_pkg::QUOTE_DOUBLE;
                    xeef_pkg::CH_SQUOTE: n_quote = xeef_pkg::QUOTE_SINGLE;
                    default: ;
                endcase
            end
        endcase
    end

    // Counted close at the target level ends the scan, as does the last byte
    assign w_hit  = w_close && (w_nest_sat == xeef_pkg::t_nest'(r_target));
    assign n_nest = w_nest_upd ? w_nest_sat : r_nest;
    assign w_emit = w_hit || r_in_last;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_wr_en) begin
            r_target <= i_cfg_wr_data;
        end
    end

    // Input register: capture a request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Scan state: advance on each processed byte, clear at end of scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nest       <= '0;
            r_quote      <= xeef_pkg::QUOTE_NONE;
            r_slash_seen <= 1'b0;
            r_prev_slash <= 1'b0;
            r_count      <= '0;
        end else if (r_in_valid && w_proc_ok) begin
            if (w_emit) begin
                r_nest       <= '0;
                r_quote      <= xeef_pkg::QUOTE_NONE;
                r_slash_seen <= 1'b0;
                r_prev_slash <= 1'b0;
                r_count      <= '0;
            end else begin
                r_nest       <= n_nest;
                r_quote      <= n_quote;
                r_slash_seen <= n_slash_seen;
                r_prev_slash <= n_prev_slash;
                r_count      <= n_count;
            end
        end
    end

    // Output register: load a result, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc_ok) begin
            r_out_valid <= r_in_valid && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc_ok && r_in_valid && w_emit) begin
            r_out_found <= w_hit;
            r_out_len   <= w_hit ? w_len : 16'd0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_len;
    assign m_axis_tuser  = r_out_found;

endmodule

/* design/xeef_checker.sv */
// Port-level checker for the XML element end finder, bound to the top level.
// Depends on xml_element_end_finder ports only.
module xeef_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A not-found result reports zero length
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
        else $error("not-found result with nonzero length");

    // A found result covers at least the slash and the closing byte
    a_found_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata >= 16'd2)
        else $error("found result with length below two");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A fresh result follows a request that passed through the input register and the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching request");

    // With the output empty the input side is always open
    a_ready_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind xml_element_end_finder xeef_checker u_xeef_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
